// File: rtl/rbsh_pkg.sv
// Shared types, constants and float helpers for the ray/box slab test.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package rbsh_pkg;

  localparam int unsigned NUM_LANES    = 3;
  localparam int unsigned FP_W         = 32;
  localparam int unsigned SUB_STAGES   = 4;
  localparam int unsigned DIV_STEPS    = 27;
  localparam int unsigned DIV_STAGES   = DIV_STEPS + 2;
  localparam int unsigned LANE_LAT     = SUB_STAGES + DIV_STAGES;
  localparam int unsigned MERGE_STAGES = 3;
  localparam int unsigned TOTAL_LAT    = LANE_LAT + MERGE_STAGES;

  localparam logic [31:0] EPS_BITS = 32'h3400_0000;
  localparam logic [31:0] BIG_BITS = 32'h7F7F_FFFF;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  // unpacked single: man has its leading one at bit 23 unless a flag is set
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [9:0]  ex;
    logic [23:0]        man;
  } ufp_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic        live;
    logic        outside;
    logic [31:0] t1;
    logic [31:0] t2;
  } lane_res_t;

  function automatic logic fp_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // monotonic key for ordering non-NaN floats
  function automatic logic [31:0] fp_key(logic [31:0] a);
    return a[31] ? ~a : {1'b1, a[30:0]};
  endfunction

  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    return !fp_nan(a) && !fp_nan(b) && !both_zero && (fp_key(a) < fp_key(b));
  endfunction

  function automatic logic fp_le(logic [31:0] a, logic [31:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    return !fp_nan(a) && !fp_nan(b) && (both_zero || (fp_key(a) <= fp_key(b)));
  endfunction

  // leading zero count, 28 when the word is zero
  function automatic logic [4:0] lzc28(logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ray_box_slab_hit.sv
// Ray versus axis-aligned box slab test on IEEE single-precision words. One
// beat in per cycle while the pipeline advances, one result beat out per
// input beat, in order. The pipeline is built from 4-stage subtractors,
// 29-stage dividers (27 quotient-bit stages plus two for window select and
// rounding, two dividers per axis) and a 3-stage merge. The whole pipeline
// advances whenever the output register is empty or being taken, so a held
// result stalls every stage at once. Denormals are kept; a miss reports
// FLT_MAX with the hit flag clear. Depends on rbsh_pkg and rbsh_lane/merge.
`default_nettype none

module ray_box_slab_hit
  import rbsh_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // box_min_x/y/z, box_max_x/y/z, ray_origin_x/y/z, ray_dir_x/y/z, 32b each
  input  wire logic [383:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // entry_distance
  output logic [31:0]       m_axis_tdata_o,
  // hit
  output logic              m_axis_tuser_o
);

  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q, vld_d;
  lane_res_t            lane_res [NUM_LANES];

  assign en              = !vld_q[TOTAL_LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[TOTAL_LAT-1];

  // beat valid travels alongside the data
  assign vld_d = {vld_q[TOTAL_LAT-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // one lane per axis
  for (genvar a = 0; a < NUM_LANES; a++) begin : g_lane
    rbsh_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .bmin_i (s_axis_tdata_i[32*a +: 32]),
      .bmax_i (s_axis_tdata_i[32*(3+a) +: 32]),
      .org_i  (s_axis_tdata_i[32*(6+a) +: 32]),
      .dir_i  (s_axis_tdata_i[32*(9+a) +: 32]),
      .res_o  (lane_res[a])
    );
  end

  rbsh_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .lane_i (lane_res),
    .hit_o  (m_axis_tuser_o),
    .dist_o (m_axis_tdata_o)
  );

  // a miss always reports the largest finite value
  a_miss_big : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == BIG_BITS))
    else $error("miss beat without FLT_MAX distance");

  // a hit distance is finite, positive and at least epsilon
  a_hit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (!m_axis_tdata_o[31] && (m_axis_tdata_o >= EPS_BITS) &&
       (m_axis_tdata_o[30:23] != 8'hFF)))
    else $error("hit distance out of range");

  // a stalled pipeline keeps its valid pattern
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: rtl/rbsh_sub.sv
// Pipelined single-precision subtract a - b, result unpacked and normalized.
// Depends on rbsh_pkg (ufp_t, lzc28). Four register stages.
`default_nettype none

module rbsh_sub
  import rbsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output ufp_t             res_o
);

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        isgn;
    logic        sgn;
    logic        op;
    logic [7:0]  el;
    logic [26:0] ml;
    logic [26:0] ms;
  } s1_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        isgn;
    logic        sgn;
    logic [7:0]  el;
    logic [27:0] sum;
  } s2_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        isgn;
    logic        sgn;
    logic        zero;
    logic [7:0]  el;
    logic [4:0]  lz;
    logic [27:0] sum;
  } s3_t;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  ufp_t res_d, res_q;

  // unpack, order by magnitude, align the smaller operand
  always_comb begin
    logic [7:0]  ea, eb, d;
    logic [23:0] ma, mb, ml, ms;
    logic        sb, a_big, a_nan, b_nan, a_inf, b_inf, stk;
    logic [26:0] ms27, shv;
    ea    = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb    = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma    = {|a_i[30:23], a_i[22:0]};
    mb    = {|b_i[30:23], b_i[22:0]};
    sb    = ~b_i[31];
    a_nan = fp_nan(a_i);
    b_nan = fp_nan(b_i);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_big = {ea, ma} >= {eb, mb};
    ml    = a_big ? ma : mb;
    ms    = a_big ? mb : ma;
    d     = a_big ? (ea - eb) : (eb - ea);
    ms27  = {ms, 3'b000};
    if (d >= 8'd27) begin
      shv = 27'd0;
      stk = |ms27;
    end else begin
      shv = ms27 >> d[4:0];
      stk = |(ms27 & ((27'd1 << d[4:0]) - 27'd1));
    end
    s1_d.nan  = a_nan || b_nan || (a_inf && b_inf && (a_i[31] == b_i[31]));
    s1_d.inf  = a_inf || b_inf;
    s1_d.isgn = a_inf ? a_i[31] : sb;
    s1_d.sgn  = a_big ? a_i[31] : sb;
    s1_d.op   = a_i[31] ^ sb;
    s1_d.el   = a_big ? ea : eb;
    s1_d.ml   = {ml, 3'b000};
    s1_d.ms   = {shv[26:1], shv[0] | stk};
  end

  // add or subtract magnitudes
  always_comb begin
    s2_d.nan  = s1_q.nan;
    s2_d.inf  = s1_q.inf;
    s2_d.isgn = s1_q.isgn;
    s2_d.sgn  = s1_q.sgn;
    s2_d.el   = s1_q.el;
    s2_d.sum  = s1_q.op ? ({1'b0, s1_q.ml} - {1'b0, s1_q.ms})
                        : ({1'b0, s1_q.ml} + {1'b0, s1_q.ms});
  end

  // leading zero count
  always_comb begin
    s3_d.nan  = s2_q.nan;
    s3_d.inf  = s2_q.inf;
    s3_d.isgn = s2_q.isgn;
    s3_d.sgn  = s2_q.sgn;
    s3_d.el   = s2_q.el;
    s3_d.sum  = s2_q.sum;
    s3_d.lz   = lzc28(s2_q.sum);
    s3_d.zero = (s2_q.sum == 28'd0);
  end

  // normalize and round to nearest even
  always_comb begin
    logic [27:0]       norm;
    logic [24:0]       mr;
    logic              inc;
    logic signed [9:0] ex;
    norm = s3_q.sum << s3_q.lz;
    inc  = norm[3] & ((|norm[2:0]) | norm[4]);
    mr   = {1'b0, norm[27:4]} + {24'd0, inc};
    ex   = $signed({2'b00, s3_q.el}) - 10'sd126 - $signed({5'b00000, s3_q.lz});
    if (mr[24]) begin
      res_d.man = mr[24:1];
      ex        = ex + 10'sd1;
    end else begin
      res_d.man = mr[23:0];
    end
    res_d.ex   = ex;
    res_d.nan  = s3_q.nan;
    res_d.inf  = !s3_q.nan && (s3_q.inf || (!s3_q.zero && (ex > 10'sd127)));
    res_d.zero = !s3_q.nan && !s3_q.inf && s3_q.zero;
    res_d.sign = s3_q.inf ? s3_q.isgn : s3_q.sgn;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: rtl/rbsh_div.sv
// Pipelined single-precision divide x / y of unpacked operands, one quotient
// bit per stage, result packed. Depends on rbsh_pkg (ufp_t, DIV_STEPS).
`default_nettype none

module rbsh_div
  import rbsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire ufp_t        x_i,
  input  wire ufp_t        y_i,
  output logic [31:0]      q_o
);

  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sign;
    logic signed [9:0] ex;
    logic [23:0]       dm;
    logic [24:0]       rem;
    logic [26:0]       q;
  } dstep_t;

  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sign;
    logic              den;
    logic signed [9:0] e;
    logic [4:0]        sh;
    logic [25:0]       ext;
  } post_t;

  // one restoring step: one quotient bit
  function automatic dstep_t div_step(dstep_t s);
    dstep_t      r;
    logic        ge;
    logic [24:0] diff;
    r    = s;
    ge   = s.rem >= {1'b0, s.dm};
    diff = s.rem - (ge ? {1'b0, s.dm} : 25'd0);
    r.rem = {diff[23:0], 1'b0};
    r.q   = {s.q[25:0], ge};
    return r;
  endfunction

  dstep_t init_d;
  dstep_t st_q [DIV_STEPS];
  post_t  p1_d, p1_q;
  logic [31:0] q_d, q_q;

  // special cases and first remainder
  always_comb begin
    init_d.nan  = x_i.nan || y_i.nan || (x_i.inf && y_i.inf) || (x_i.zero && y_i.zero);
    init_d.inf  = !init_d.nan && (x_i.inf || y_i.zero);
    init_d.zero = !init_d.nan && !init_d.inf && (x_i.zero || y_i.inf);
    init_d.sign = x_i.sign ^ y_i.sign;
    init_d.ex   = x_i.ex - y_i.ex;
    init_d.dm   = y_i.man;
    init_d.rem  = {1'b0, x_i.man};
    init_d.q    = 27'd0;
  end

  // quotient bit pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(init_d);
    end
  end

  for (genvar i = 1; i < DIV_STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= div_step(st_q[i-1]);
      end
    end
  end

  // select quotient window, work out denormal shift
  always_comb begin
    dstep_t            s;
    logic              stk;
    logic signed [9:0] e, shv;
    s   = st_q[DIV_STEPS-1];
    stk = |s.rem;
    if (s.q[26]) begin
      p1_d.ext = {s.q[26:3], s.q[2], (|s.q[1:0]) | stk};
      e        = s.ex;
    end else begin
      p1_d.ext = {s.q[25:2], s.q[1], s.q[0] | stk};
      e        = s.ex - 10'sd1;
    end
    shv       = -10'sd126 - e;
    p1_d.den  = e < -10'sd126;
    p1_d.sh   = !p1_d.den ? 5'd0 : ((shv > 10'sd26) ? 5'd26 : shv[4:0]);
    p1_d.e    = e;
    p1_d.nan  = s.nan;
    p1_d.inf  = s.inf;
    p1_d.zero = s.zero;
    p1_d.sign = s.sign;
  end

  // denormal shift, round to nearest even, pack
  always_comb begin
    logic [25:0]       sv;
    logic [26:0]       msk;
    logic              stk, inc;
    logic [24:0]       mr;
    logic signed [9:0] eb;
    msk = (27'd1 << p1_q.sh) - 27'd1;
    stk = |({1'b0, p1_q.ext} & msk);
    sv  = p1_q.ext >> p1_q.sh;
    sv[0] = sv[0] | stk;
    inc = sv[1] & (sv[0] | sv[2]);
    mr  = {1'b0, sv[25:2]} + {24'd0, inc};
    eb  = p1_q.e + (mr[24] ? 10'sd128 : 10'sd127);
    if (p1_q.nan) begin
      q_d = QNAN_BITS;
    end else if (p1_q.inf) begin
      q_d = {p1_q.sign, 8'hFF, 23'd0};
    end else if (p1_q.zero) begin
      q_d = {p1_q.sign, 31'd0};
    end else if (p1_q.den) begin
      q_d = {p1_q.sign, 7'd0, mr[23], mr[22:0]};
    end else if (eb >= 10'sd255) begin
      q_d = {p1_q.sign, 8'hFF, 23'd0};
    end else begin
      q_d = {p1_q.sign, eb[7:0], mr[24] ? 23'd0 : mr[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
      q_q  <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// File: rtl/rbsh_lane.sv
// One axis of the slab test: two subtracts, direction unpack, two divides,
// and the zero-direction side flags. Depends on rbsh_pkg, rbsh_sub, rbsh_div.
`default_nettype none

module rbsh_lane
  import rbsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] bmin_i,
  input  wire logic [31:0] bmax_i,
  input  wire logic [31:0] org_i,
  input  wire logic [31:0] dir_i,
  output lane_res_t        res_o
);

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic [7:0]  e;
    logic [23:0] m;
    logic [4:0]  lz;
  } dpre_t;

  typedef struct packed {
    logic live;
    logic outside;
  } side_t;

  ufp_t  d1_sub, d2_sub;
  dpre_t da_d, da_q;
  ufp_t  db_d, db_q, dc_q, dd_q;
  side_t side_d;
  side_t side_q [LANE_LAT];
  logic [31:0] t1, t2;

  rbsh_sub u_sub_min (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (bmin_i),
    .b_i   (org_i),
    .res_o (d1_sub)
  );

  rbsh_sub u_sub_max (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (bmax_i),
    .b_i   (org_i),
    .res_o (d2_sub)
  );

  // direction unpack: count leading zeros of the significand
  always_comb begin
    da_d.nan  = fp_nan(dir_i);
    da_d.inf  = (dir_i[30:23] == 8'hFF) && (dir_i[22:0] == 23'd0);
    da_d.zero = (dir_i[30:0] == 31'd0);
    da_d.sign = dir_i[31];
    da_d.e    = (dir_i[30:23] == 8'd0) ? 8'd1 : dir_i[30:23];
    da_d.m    = {|dir_i[30:23], dir_i[22:0]};
    da_d.lz   = lzc28({da_d.m, 4'hF});
  end

  // direction normalize
  always_comb begin
    db_d.nan  = da_q.nan;
    db_d.inf  = da_q.inf;
    db_d.zero = da_q.zero;
    db_d.sign = da_q.sign;
    db_d.man  = da_q.m << da_q.lz;
    db_d.ex   = $signed({2'b00, da_q.e}) - 10'sd127 - $signed({5'b00000, da_q.lz});
  end

  // zero-direction axis: live flag and origin outside the slab
  always_comb begin
    side_d.live    = (dir_i[30:0] != 31'd0);
    side_d.outside = !side_d.live && (fp_lt(org_i, bmin_i) || fp_lt(bmax_i, org_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da_q      <= da_d;
      db_q      <= db_d;
      dc_q      <= db_q;
      dd_q      <= dc_q;
      side_q[0] <= side_d;
    end
  end

  for (genvar i = 1; i < LANE_LAT; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  rbsh_div u_div_min (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (d1_sub),
    .y_i   (dd_q),
    .q_o   (t1)
  );

  rbsh_div u_div_max (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (d2_sub),
    .y_i   (dd_q),
    .q_o   (t2)
  );

  assign res_o.live    = side_q[LANE_LAT-1].live;
  assign res_o.outside = side_q[LANE_LAT-1].outside;
  assign res_o.t1      = t1;
  assign res_o.t2      = t2;

endmodule

`default_nettype wire

// File: rtl/rbsh_merge.sv
// Merges the three axis results into hit flag and entry distance.
// Depends on rbsh_pkg (lane_res_t, compare helpers). Three register stages.
`default_nettype none

module rbsh_merge
  import rbsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire lane_res_t   lane_i [NUM_LANES],
  output logic             hit_o,
  output logic [31:0]      dist_o
);

  typedef struct packed {
    logic        live;
    logic        miss;
    logic [31:0] near;
    logic [31:0] far;
  } axis_t;

  axis_t       ax_d [NUM_LANES];
  axis_t       ax_q [NUM_LANES];
  logic        miss_d, miss_q;
  logic [31:0] tmin_d, tmin_q, tmax_d, tmax_q;
  logic        hit_d, hit_q;
  logic [31:0] dist_d, dist_q;

  // per axis: behind test and near/far order
  for (genvar a = 0; a < NUM_LANES; a++) begin : g_axis
    always_comb begin
      logic behind;
      behind        = fp_lt(lane_i[a].t1, 32'd0) && fp_lt(lane_i[a].t2, 32'd0);
      ax_d[a].live  = lane_i[a].live;
      ax_d[a].miss  = lane_i[a].outside || (lane_i[a].live && behind);
      ax_d[a].near  = fp_lt(lane_i[a].t1, lane_i[a].t2) ? lane_i[a].t1 : lane_i[a].t2;
      ax_d[a].far   = fp_lt(lane_i[a].t2, lane_i[a].t1) ? lane_i[a].t1 : lane_i[a].t2;
    end
  end

  // running entry and exit over live axes
  always_comb begin
    miss_d = 1'b0;
    tmin_d = EPS_BITS;
    tmax_d = BIG_BITS;
    for (int a = 0; a < NUM_LANES; a++) begin
      miss_d = miss_d || ax_q[a].miss;
      if (ax_q[a].live && fp_lt(tmin_d, ax_q[a].near)) begin
        tmin_d = ax_q[a].near;
      end
      if (ax_q[a].live && fp_lt(ax_q[a].far, tmax_d)) begin
        tmax_d = ax_q[a].far;
      end
    end
  end

  // final overlap check
  always_comb begin
    hit_d  = !miss_q && fp_le(tmin_q, tmax_q);
    dist_d = hit_d ? tmin_q : BIG_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d;
      miss_q <= miss_d;
      tmin_q <= tmin_d;
      tmax_q <= tmax_d;
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign hit_o  = hit_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// File: bench/tb_ray_box_slab_hit.sv
// Self-checking bench for ray_box_slab_hit: a queue-fed stream driver, a
// result monitor and a bit-exact single-precision slab-test predictor.
// Depends on rbsh_pkg and the ray_box_slab_hit RTL.
`timescale 1ns / 100ps

module tb_ray_box_slab_hit;
  import rbsh_pkg::*;

  localparam int unsigned N_RANDOM   = 1000;
  localparam int unsigned TAIL_ITEMS = 150;
  localparam int unsigned PAUSE_AT   = 400;
  localparam int unsigned MAX_CYCLES = 400000;

  localparam logic [31:0] F_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_NZ   = 32'h8000_0000;
  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_NEG1 = 32'hBF80_0000;
  localparam logic [31:0] F_TWO  = 32'h4000_0000;
  localparam logic [31:0] F_FOUR = 32'h4080_0000;
  localparam logic [31:0] F_ONE5 = 32'h3FC0_0000;
  localparam logic [31:0] F_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NINF = 32'hFF80_0000;
  localparam logic [31:0] F_DEN  = 32'h0000_0001;

  typedef struct packed {
    logic        hit;
    logic [31:0] entry_dist;
  } slab_res_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;

  logic [383:0] ray_q[$];
  slab_res_t    hit_q[$];
  int unsigned  n_sent, n_total, n_err;
  int unsigned  n_cycles = 0;
  int unsigned  send_gap, recv_gap;
  logic         pause_done;
  logic         drv_valid;

  ray_box_slab_hit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------
  // Single-precision arithmetic, round to nearest even, denormals kept
  // ---------------------------------------------------------------------
  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 0);
  endfunction

  // total order for non-NaN values, both zeros map to 0
  function automatic longint ord_val(logic [31:0] a);
    return a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
  endfunction

  function automatic logic f_less(logic [31:0] a, logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && (ord_val(a) < ord_val(b));
  endfunction

  function automatic logic [23:0] sig_of(logic [31:0] a);
    return {(a[30:23] != 0), a[22:0]};
  endfunction

  // unbiased exponent of the significand's lsb
  function automatic int lsb_exp(logic [31:0] a);
    return ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  // round sgn * mag * 2^e to a single
  function automatic logic [31:0] round_pack(logic sgn, logic [127:0] mag, int e);
    int p, sh, q;
    logic [127:0] kept, rem, half;
    if (mag == 0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    if (p + e >= -126) sh = p - 23;
    else sh = -149 - e;
    q = e + sh;
    if (sh <= 0) begin
      kept = mag << (-sh);
    end else if (sh > p + 1) begin
      kept = 0;
    end else begin
      kept = mag >> sh;
      rem  = mag & ((128'd1 << sh) - 1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    end
    if (kept[24]) begin
      kept = kept >> 1;
      q++;
    end
    if (kept == 0) return {sgn, 31'd0};
    if (kept[23]) begin
      if (q + 150 >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(q + 150), kept[22:0]};
    end
    return {sgn, 8'd0, kept[22:0]};
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    logic sb, sx, sy, sgn;
    logic [31:0] x, y;
    logic [127:0] mx, my, mag;
    int d;
    if (is_nan(a) || is_nan(b)) return QNAN_BITS;
    sb = ~b[31];
    if (is_inf(a) && is_inf(b) && a[31] != sb) return QNAN_BITS;
    if (is_inf(a)) return a;
    if (is_inf(b)) return {sb, b[30:0]};
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & sb, 31'd0};
    // x holds the larger exponent
    if (lsb_exp(a) >= lsb_exp(b)) begin
      x = a; sx = a[31]; y = b; sy = sb;
    end else begin
      x = b; sx = sb; y = a; sy = a[31];
    end
    d  = lsb_exp(x) - lsb_exp(y);
    mx = 128'(sig_of(x)) << 40;
    if (d <= 40) my = 128'(sig_of(y)) << (40 - d);
    else if (d >= 64) my = 128'(sig_of(y) != 0);
    else begin
      my = 128'(sig_of(y)) >> (d - 40);
      if ((128'(sig_of(y)) & ((128'd1 << (d - 40)) - 1)) != 0) my[0] = 1'b1;
    end
    if (sx == sy) begin
      mag = mx + my; sgn = sx;
    end else if (mx >= my) begin
      mag = mx - my; sgn = sx;
    end else begin
      mag = my - mx; sgn = sy;
    end
    if (mag == 0) return F_ZERO;
    return round_pack(sgn, mag, lsb_exp(x) - 40);
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    logic sgn;
    logic [127:0] num, quo;
    if (is_nan(a) || is_nan(b)) return QNAN_BITS;
    sgn = a[31] ^ b[31];
    if (is_inf(a) && is_inf(b)) return QNAN_BITS;
    if (is_inf(a)) return {sgn, 8'hFF, 23'd0};
    if (is_inf(b)) return {sgn, 31'd0};
    if (b[30:0] == 0) return (a[30:0] == 0) ? QNAN_BITS : {sgn, 8'hFF, 23'd0};
    if (a[30:0] == 0) return {sgn, 31'd0};
    num = 128'(sig_of(a)) << 60;
    quo = num / 128'(sig_of(b));
    if (num % 128'(sig_of(b)) != 0) quo[0] = 1'b1;
    return round_pack(sgn, quo, lsb_exp(a) - lsb_exp(b) - 60);
  endfunction

  // ---------------------------------------------------------------------
  // Slab test predictor
  // ---------------------------------------------------------------------
  function automatic slab_res_t slab_predict(logic [383:0] v);
    logic [31:0] mn[3], mx[3], org[3], dir[3], nr[3], fr[3];
    logic [31:0] t1, t2, t_in, t_out;
    logic        active[3];
    slab_res_t   miss;
    miss.hit        = 1'b0;
    miss.entry_dist = BIG_BITS;
    for (int k = 0; k < 3; k++) begin
      mn[k]  = v[32*k +: 32];
      mx[k]  = v[32*(3+k) +: 32];
      org[k] = v[32*(6+k) +: 32];
      dir[k] = v[32*(9+k) +: 32];
    end
    // parallel axis: origin must sit within the slab
    for (int k = 0; k < 3; k++) begin
      active[k] = (dir[k][30:0] != 0);
      if (!active[k] && (f_less(org[k], mn[k]) || f_less(mx[k], org[k]))) return miss;
    end
    for (int k = 0; k < 3; k++) begin
      nr[k] = F_ZERO;
      fr[k] = F_ZERO;
      if (active[k]) begin
        t1 = f_div(f_sub(mn[k], org[k]), dir[k]);
        t2 = f_div(f_sub(mx[k], org[k]), dir[k]);
        if (f_less(t1, F_ZERO) && f_less(t2, F_ZERO)) return miss;
        nr[k] = f_less(t1, t2) ? t1 : t2;
        fr[k] = f_less(t2, t1) ? t1 : t2;
      end
    end
    t_in  = EPS_BITS;
    t_out = BIG_BITS;
    for (int k = 0; k < 3; k++) begin
      if (active[k]) begin
        if (f_less(t_in, nr[k])) t_in = nr[k];
        if (f_less(fr[k], t_out)) t_out = fr[k];
      end
    end
    if (f_less(t_out, t_in)) return miss;
    return '{hit: 1'b1, entry_dist: t_in};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [31:0] mid_float();
    return {1'($urandom), 8'($urandom_range(124, 131)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] any_float();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 31'd0};
      1: return {1'($urandom), 8'hFF, 23'd0};
      2: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      3: return {1'($urandom), 8'd0, 23'($urandom)};
      4: return {1'($urandom), ($urandom_range(0, 1) ? 31'h7F7F_FFFF : 31'h0080_0000)};
      5, 6: return $urandom;
      default: return mid_float();
    endcase
  endfunction

  task automatic add_ray(input logic [31:0] n0, n1, n2, x0, x1, x2,
                         input logic [31:0] o0, o1, o2, d0, d1, d2);
    ray_q.push_back({d2, d1, d0, o2, o1, o0, x2, x1, x0, n2, n1, n0});
  endtask

  // box, origin and a direction that mostly points at the box
  task automatic add_aimed_ray();
    logic [31:0] lo, hi, tmp, o, d;
    logic [383:0] v;
    for (int k = 0; k < 3; k++) begin
      lo = mid_float();
      hi = mid_float();
      if (f_less(hi, lo)) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      o = mid_float();
      if ($urandom_range(0, 9) == 0) d = {1'($urandom), 31'd0};
      else begin
        d = mid_float();
        d[31] = f_less(hi, o);
        if ($urandom_range(0, 6) == 0) d[31] = ~d[31];
      end
      v[32*k +: 32]     = lo;
      v[32*(3+k) +: 32] = hi;
      v[32*(6+k) +: 32] = o;
      v[32*(9+k) +: 32] = d;
    end
    ray_q.push_back(v);
  endtask

  task automatic add_noise_ray();
    logic [383:0] v;
    for (int k = 0; k < 12; k++) v[32*k +: 32] = any_float();
    ray_q.push_back(v);
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset and stimulus
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    // hit at t = 1, ray from the origin into a unit-offset box
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ONE, F_ONE);
    // origin inside: entry floored at epsilon
    add_ray(F_NEG1, F_NEG1, F_NEG1, F_ONE, F_ONE, F_ONE,
            F_ZERO, F_ZERO, F_ZERO, F_ONE, F_NEG1, F_ONE);
    // box behind the origin
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ZERO, F_ZERO, F_ZERO, F_NEG1, F_NEG1, F_NEG1);
    // zero x direction, origin inside the x slab
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ONE5, F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ONE);
    // negative zero direction, origin outside the slab
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ZERO, F_ZERO, F_ZERO, F_NZ, F_ONE, F_ONE);
    // every axis parallel and inside
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ONE5, F_ONE5, F_ONE5, F_ZERO, F_NZ, F_ZERO);
    // NaN origin on a parallel axis is skipped
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            QNAN_BITS, F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ONE);
    // NaN direction gives NaN slab distances
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ZERO, F_ZERO, F_ZERO, QNAN_BITS, F_ONE, F_ONE);
    // infinite direction
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ZERO, F_ZERO, F_ZERO, F_INF, F_ONE, F_NINF);
    // reversed box
    add_ray(F_TWO, F_TWO, F_TWO, F_ONE, F_ONE, F_ONE,
            F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ONE, F_ONE);
    // denormal direction overflows the distance
    add_ray(F_ONE, F_NEG1, F_NEG1, F_TWO, F_ONE, F_ONE,
            F_ZERO, F_ZERO, F_ZERO, F_DEN, F_ONE, F_ONE);
    // extreme bounds
    add_ray(F_NINF, BIG_BITS | F_NZ, F_NEG1, F_INF, BIG_BITS, F_ONE,
            F_ZERO, F_ZERO, F_ZERO, F_ONE, F_FOUR, F_DEN);
    add_ray(BIG_BITS, F_ONE, F_ONE, F_INF, F_TWO, F_TWO,
            BIG_BITS | F_NZ, F_ZERO, F_ZERO, BIG_BITS, F_ONE, F_ONE);
    // all bits low, all bits high
    ray_q.push_back('0);
    ray_q.push_back('1);
    // slabs that do not overlap
    add_ray(F_ONE, F_ONE, F_ONE, F_TWO, F_TWO, F_TWO,
            F_ZERO, F_ZERO, F_ZERO, F_ONE, F_FOUR, F_ONE);
    // denormal box, tiny distances
    add_ray(F_DEN, F_DEN, F_DEN, 32'h0000_0010, 32'h0000_0010, 32'h0000_0010,
            F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ONE, F_ONE);
    add_ray(F_NEG1, F_NEG1, F_NEG1, F_ONE, F_ONE, F_ONE,
            F_DEN, F_NZ, F_ZERO, 32'h0000_0002, F_DEN, F_INF);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 4) == 0) add_noise_ray();
      else add_aimed_ray();
    end
    n_total = ray_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_sent == n_total && hit_q.size() == 0);
    repeat (TOTAL_LAT + 20) @(posedge clk_i);
    if (n_err == 0 && hit_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: one beat per handshake, random gaps, one drain pause
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      n_sent        <= 0;
      send_gap      <= 0;
      pause_done    <= 1'b0;
    end else begin
      drv_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        hit_q.push_back(slab_predict(s_axis_tdata));
        n_sent <= n_sent + 1;
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (!pause_done && n_sent + (s_axis_tvalid && s_axis_tready) == PAUSE_AT) begin
          // hold off until the pipeline has drained
          if (hit_q.size() == 0) pause_done <= 1'b1;
        end else if (ray_q.size() != 0) begin
          drv_valid = 1'b1;
          s_axis_tdata <= ray_q.pop_front();
          if (ray_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
            send_gap <= $urandom_range(1, 10);
        end
      end
      s_axis_tvalid <= drv_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, compare against oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      n_err         <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hit_q.size() == 0) begin
          n_err <= n_err + 1;
          if (n_err < 10)
            $display("unexpected beat: hit=%0b dist=%08h", m_axis_tuser, m_axis_tdata);
        end else begin
          automatic slab_res_t want = hit_q.pop_front();
          if (want.hit !== m_axis_tuser || want.entry_dist !== m_axis_tdata) begin
            n_err <= n_err + 1;
            if (n_err < 10)
              $display("mismatch: expected hit=%0b dist=%08h, got hit=%0b dist=%08h",
                       want.hit, want.entry_dist, m_axis_tuser, m_axis_tdata);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (n_sent + TAIL_ITEMS < n_total && $urandom_range(0, 7) == 0) begin
        recv_gap      <= $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
